>>> hdl/ncat_pkg.sv
// ----------------------------------------------------------------------------
// ncat_pkg
// Shared types and constants of the neighbor cache aging table.
// ----------------------------------------------------------------------------
package ncat_pkg;

  typedef enum logic [1:0] {
    ActTick   = 2'd0,
    ActAdd    = 2'd1,
    ActUpdate = 2'd2,
    ActLookup = 2'd3
  } action_e;

  localparam logic [7:0] MaxAgeReset = 8'd128;

  typedef struct packed {
    action_e     action;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic [2:0]  slot;
  } res_t;

endpackage

>>> hdl/ncat_ram.sv
// ----------------------------------------------------------------------------
// ncat_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ncat_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hdl/ncat_front.sv
// ----------------------------------------------------------------------------
// ncat_front
// Input stage: accepts commands into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module ncat_front import ncat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic cmd_valid_o,
  input  logic cmd_take_i,
  output cmd_t cmd_o
);
  cmd_t buf_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

>>> hdl/ncat_engine.sv
// ----------------------------------------------------------------------------
// ncat_engine
// Table engine: scans a slot per cycle save in tick stalls, writes the result.
// ----------------------------------------------------------------------------
module ncat_engine import ncat_pkg::*; #(
  parameter int Entries = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] max_age_i,
  input  logic       cmd_valid_i,
  output logic       cmd_take_o,
  input  cmd_t       cmd_i,
  output logic       res_valid_o,
  input  logic       res_take_i,
  output res_t       res_o
);
  localparam int Aw = $clog2(Entries > 1 ? Entries : 2);
  localparam int Cw = $clog2(Entries + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StWrite = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cmd_q;
  logic [Cw-1:0] idx_q;
  logic [Aw-1:0] addr;
  logic        rd_vld_q;
  logic [Aw-1:0] rd_idx_q;
  logic [Entries-1:0] valid_q;
  logic [Aw-1:0] pick_q;
  logic [7:0]  best_q;
  logic        found_q;
  logic [47:0] mac_q;
  res_t        res_q;
  logic        res_valid_q;

  logic        we;
  logic [31:0] ip_w, ip_r;
  logic [47:0] mac_w, mac_r;
  logic [7:0]  age_w, age_r, age_v;
  logic        wr_ip, wr_mac;
  logic [31:0] ip_v;
  logic [47:0] mac_v;
  logic        scan_last, hit_now, stop_now, is_tick, tick_wr;

  ncat_ram #(.Width(32), .Depth(Entries)) u_ip (
    .clk_i, .we_i(wr_ip), .addr_i(addr), .wdata_i(ip_w), .rdata_o(ip_r));
  ncat_ram #(.Width(48), .Depth(Entries)) u_mac (
    .clk_i, .we_i(wr_mac), .addr_i(addr), .wdata_i(mac_w), .rdata_o(mac_r));
  ncat_ram #(.Width(8), .Depth(Entries)) u_age (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(age_w), .rdata_o(age_r));

  assign ip_v  = valid_q[rd_idx_q] ? ip_r : 32'd0;
  assign mac_v = valid_q[rd_idx_q] ? mac_r : 48'd0;
  assign age_v = valid_q[rd_idx_q] ? age_r : MaxAgeReset;

  assign is_tick   = (cmd_q.action == ActTick);
  assign tick_wr   = is_tick && rd_vld_q && (age_v < max_age_i);
  assign hit_now   = rd_vld_q && (ip_v == cmd_q.ip_addr ||
                     (cmd_q.action == ActAdd && age_v == max_age_i));
  assign scan_last = rd_vld_q && (rd_idx_q == Aw'(Entries - 1));
  assign stop_now  = (!is_tick && hit_now) || scan_last;

  assign cmd_take_o  = (state_q == StIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    addr    = idx_q[Aw-1:0];
    we      = 1'b0;
    wr_ip   = 1'b0;
    wr_mac  = 1'b0;
    ip_w    = cmd_q.ip_addr;
    mac_w   = cmd_q.mac_addr;
    age_w   = 8'd0;
    unique case (state_q)
      StIdle: if (cmd_valid_i && cmd_take_o) state_d = StScan;
      StScan: begin
        if (tick_wr) begin
          addr  = rd_idx_q;
          we    = 1'b1;
          wr_ip = 1'b1;
          wr_mac = 1'b1;
          ip_w  = ip_v;
          mac_w = mac_v;
          age_w = age_v + 8'd1;
        end
        if (stop_now) state_d = StWrite;
      end
      StWrite: begin
        addr = pick_q;
        state_d = StDone;
        if (cmd_q.action == ActAdd) begin
          we = 1'b1; wr_ip = 1'b1; wr_mac = 1'b1;
        end else if (cmd_q.action == ActUpdate && found_q) begin
          we = 1'b1; wr_ip = 1'b1; wr_mac = 1'b1;
          ip_w = cmd_q.ip_addr; mac_w = mac_q;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      valid_q     <= '0;
      pick_q      <= '0;
      best_q      <= '0;
      found_q     <= 1'b0;
      mac_q       <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_take_i) res_valid_q <= 1'b0;
      if (we) valid_q[addr] <= 1'b1;
      unique case (state_q)
        StIdle: begin
          idx_q    <= '0;
          rd_vld_q <= 1'b0;
          pick_q   <= '0;
          best_q   <= '0;
          found_q  <= 1'b0;
        end
        StScan: begin
          if (tick_wr) begin
            rd_vld_q <= 1'b0;
          end else begin
            rd_vld_q <= (idx_q < Cw'(Entries)) && !stop_now;
            rd_idx_q <= idx_q[Aw-1:0];
            if (idx_q < Cw'(Entries)) idx_q <= idx_q + Cw'(1);
          end
          if (rd_vld_q && !is_tick) begin
            if (hit_now) begin
              pick_q  <= rd_idx_q;
              found_q <= 1'b1;
              mac_q   <= mac_v;
            end else if (cmd_q.action == ActAdd && age_v > best_q) begin
              pick_q <= rd_idx_q;
              best_q <= age_v;
            end
          end
        end
        StWrite: begin
          res_q.hit     <= (cmd_q.action == ActAdd) || (!is_tick && found_q);
          res_q.slot    <= (is_tick || (cmd_q.action != ActAdd && !found_q)) ?
                           3'd0 : 3'(pick_q);
          res_q.mac_out <= (cmd_q.action == ActLookup && found_q) ? mac_q : 48'd0;
          res_valid_q   <= 1'b1;
        end
        StDone: ;
        default: ;
      endcase
    end
  end
endmodule

>>> hdl/neighbor_cache_aging_table.sv
// ----------------------------------------------------------------------------
// neighbor_cache_aging_table
// IPv4-to-MAC neighbor cache with aging and oldest-slot replacement.
// ----------------------------------------------------------------------------
// Commands enter through a queue interface: push with full, a transfer
// happening when push is high and full low. Results leave as a queue:
// while empty is low the oldest result is on hit_o, mac_out_o and slot_o,
// and pop takes it. A two-entry command queue decouples the producer from
// the table engine. The engine reads the three slot memories one slot per
// cycle, then writes back an add or a found update; a match stops the scan
// of an add, update or lookup early. A tick pauses that scan on every slot
// that it ages, to write the slot back, since the single-port memories
// cannot read and write at once. The engine holds a finished result until
// it is popped and takes no new command meanwhile; the queue keeps
// accepting until it is full. At reset the queues empty, max_age returns
// to 128 and per-slot valid bits clear so that every slot reads as IP 0,
// MAC 0 and age 128. max_age is written through cfg_valid_i / cfg_ready_o;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module neighbor_cache_aging_table import ncat_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] mac_addr_i,
  output logic        empty,
  input  logic        pop,
  output logic        hit_o,
  output logic [47:0] mac_out_o,
  output logic [2:0]  slot_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  logic [7:0] max_age_q;
  cmd_t cmd_in, cmd;
  logic cmd_valid, cmd_take, res_valid;
  res_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_age_q <= MaxAgeReset;
    else if (cfg_valid_i) max_age_q <= cfg_data_i;
  end

  assign cmd_in.action   = action_e'(action_i);
  assign cmd_in.ip_addr  = ip_addr_i;
  assign cmd_in.mac_addr = mac_addr_i;

  ncat_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .cmd_i(cmd_in),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd));

  ncat_engine #(.Entries(ENTRIES)) u_engine (
    .clk_i, .rst_ni, .max_age_i(max_age_q), .cmd_valid_i(cmd_valid),
    .cmd_take_o(cmd_take), .cmd_i(cmd), .res_valid_o(res_valid),
    .res_take_i(pop), .res_o(res));

  assign empty     = !res_valid;
  assign hit_o     = res.hit;
  assign mac_out_o = res.mac_out;
  assign slot_o    = res.slot;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the neighbor cache aging table. A software copy
// of the slot table predicts every result, and a scoreboard compares each
// popped result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ncat_pkg::*;

  localparam int NumSlots = 8;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 40;

  class neighbor_scoreboard;
    logic [31:0] ip_tab[NumSlots];
    logic [47:0] mac_tab[NumSlots];
    logic [7:0]  age_tab[NumSlots];
    logic [7:0]  max_age;
    res_t        pending[$];
    int          errors;

    function void clear_table();
      max_age = MaxAgeReset;
      for (int i = 0; i < NumSlots; i++) begin
        ip_tab[i] = '0;
        mac_tab[i] = '0;
        age_tab[i] = MaxAgeReset;
      end
      errors = 0;
    endfunction

    function void note_command(cmd_t c);
      res_t r;
      int pick;
      logic [7:0] best;
      r = '0;
      case (c.action)
        ActTick: begin
          for (int i = 0; i < NumSlots; i++)
            if (age_tab[i] < max_age) age_tab[i] = age_tab[i] + 8'd1;
        end
        ActAdd: begin
          pick = 0;
          best = '0;
          for (int i = 0; i < NumSlots; i++) begin
            if (ip_tab[i] == c.ip_addr || age_tab[i] == max_age) begin
              pick = i;
              break;
            end
            if (age_tab[i] > best) begin
              pick = i;
              best = age_tab[i];
            end
          end
          ip_tab[pick] = c.ip_addr;
          mac_tab[pick] = c.mac_addr;
          age_tab[pick] = '0;
          r.hit = 1'b1;
          r.slot = pick[2:0];
        end
        default: begin
          for (int i = 0; i < NumSlots; i++) begin
            if (ip_tab[i] == c.ip_addr) begin
              r.hit = 1'b1;
              r.slot = i[2:0];
              if (c.action == ActUpdate) age_tab[i] = '0;
              else r.mac_out = mac_tab[i];
              break;
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (pending.size() == 0) begin
        $error("Unexpected result hit=%0d slot=%0d", got.hit, got.slot);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d, actual %0d", exp_r.hit, got.hit);
        errors++;
      end
      if (got.mac_out !== exp_r.mac_out) begin
        $error("mac_out: expected %h, actual %h", exp_r.mac_out, got.mac_out);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, actual %0d", exp_r.slot, got.slot);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action_i = '0;
  logic [31:0] ip_addr_i = '0;
  logic [47:0] mac_addr_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        hit_o;
  logic [47:0] mac_out_o;
  logic [2:0]  slot_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  neighbor_scoreboard sb;
  int push_idle_pct;
  int pop_idle_pct;
  int idle_cycles;
  logic [31:0] ip_pool[16];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  neighbor_cache_aging_table #(.ENTRIES(NumSlots)) u_dut (
    .clk_i, .rst_ni, .push, .full, .action_i, .ip_addr_i, .mac_addr_i,
    .empty, .pop, .hit_o, .mac_out_o, .slot_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result('{hit: hit_o, mac_out: mac_out_o, slot: slot_o});
      if ((pop && !empty) || (push && !full) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  task automatic send_command(action_e act, logic [31:0] ip, logic [47:0] mac);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    action_i <= act;
    ip_addr_i <= ip;
    mac_addr_i <= mac;
    do @(posedge clk_i); while (full);
    sb.note_command('{action: act, ip_addr: ip, mac_addr: mac});
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_max_age(logic [7:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.max_age = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    action_e act;
    logic [31:0] ip;
    for (int n = 0; n < count; n++) begin
      act = action_e'($urandom_range(3));
      if ($urandom_range(9) < 8) ip = ip_pool[$urandom_range(15)];
      else ip = $urandom();
      send_command(act, ip, 48'({$urandom(), $urandom()}));
    end
  endtask

  initial begin
    sb = new();
    sb.clear_table();
    idle_cycles = 0;
    push_idle_pct = 0;
    pop_idle_pct = 0;
    for (int i = 0; i < 16; i++) ip_pool[i] = $urandom();
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(ActLookup, 32'h0, 48'h0);
    send_command(ActUpdate, 32'h0, '1);
    send_command(ActAdd, '1, '1);
    send_command(ActAdd, 32'h0A00_0001, 48'h0);
    send_command(ActLookup, '1, '0);
    send_command(ActLookup, 32'h1234_5678, '1);
    send_command(ActUpdate, 32'h0A00_0001, '0);
    send_command(ActUpdate, 32'h5555_5555, '0);
    send_command(ActTick, '1, '1);
    send_command(ActAdd, '1, 48'h5555_5555_5555);
    for (int i = 0; i < 8; i++)
      send_command(ActAdd, 32'hC0A8_0000 + 32'(i), 48'hAAAA_0000_0000 + 48'(i));
    send_command(ActAdd, 32'hC0A8_0100, 48'h1);
    send_command(ActTick, '0, '0);
    send_command(ActUpdate, 32'hC0A8_0003, '0);

    write_max_age(8'd1);
    send_command(ActTick, '0, '0);
    send_command(ActAdd, 32'hDEAD_BEEF, '1);
    send_command(ActLookup, 32'hDEAD_BEEF, '0);
    write_max_age(8'd0);
    send_command(ActTick, '0, '0);
    send_command(ActAdd, 32'hFEED_0000, 48'h1234);

    push_idle_pct = 38;
    pop_idle_pct = 60;
    write_max_age(8'd3);
    random_phase(400);
    wait_drained();
    push_idle_pct = 60;
    pop_idle_pct = 38;
    write_max_age(8'd255);
    random_phase(400);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    write_max_age(8'd2);
    random_phase(400);
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
